/* hdl/mqp_pkg.sv */
// ----------------------------------------------------------------------------
// mqp_pkg
// Shared types and constants for the mouse quadrature port logic.
// ----------------------------------------------------------------------------
package mqp_pkg;

    typedef enum logic [1:0] {
        OP_REPORT    = 2'd0,
        OP_TICK      = 2'd1,
        OP_CLOCK_BIT = 2'd2,
        OP_OVERWRITE = 2'd3
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [7:0]  mouse_dx;
        logic signed [7:0]  mouse_dy;
        logic [2:0]         buttons;
        logic [7:0]         value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] port_value;
        logic       port_changed;
        logic       phase_x_valid;
        logic       phase_x;
        logic       phase_y_valid;
        logic       phase_y;
    } t_out_item;

    // Per-axis step result handed to the port update logic
    typedef struct packed {
        logic step;
        logic port_bit;
    } t_axis_ctl;

    localparam int unsigned BIT_CLOCK  = 0;
    localparam int unsigned BIT_BUTTON = 3;
    localparam int unsigned BIT_X      = 4;
    localparam int unsigned BIT_Y      = 5;

    localparam logic [7:0] PORT_RESET = 8'h88;

endpackage

/* hdl/mqp_axis.sv */
// ----------------------------------------------------------------------------
// mqp_axis
// Next-state logic of one motion axis: saturating accumulate on a report,
// one quadrature step of 2 counts toward zero on a tick.
// ----------------------------------------------------------------------------
module mqp_axis #(
    parameter int unsigned P_ACCUM_WIDTH = 16,
    parameter bit          P_INV_POS     = 1'b1
) (
    input  mqp_pkg::t_op                    i_op,
    input  logic signed [7:0]               i_delta,
    input  logic signed [P_ACCUM_WIDTH-1:0] i_accum,
    input  logic                            i_phase,
    output logic signed [P_ACCUM_WIDTH-1:0] o_accum_next,
    output logic                            o_phase_next,
    output mqp_pkg::t_axis_ctl              o_ctl
);
    import mqp_pkg::*;

    localparam int unsigned W = P_ACCUM_WIDTH;
    localparam logic signed [W-1:0] ACC_TWO = W'(2);
    localparam logic signed [W-1:0] ACC_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] ACC_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W:0]   sum;
    logic signed [W-1:0] sat;
    logic                can_step;
    logic                pos;
    logic                flip;

    // Saturate when the extra sum bit disagrees with the sign bit
    assign sum = {i_accum[W-1], i_accum} + {{(W-7){i_delta[7]}}, i_delta};
    assign sat = (sum[W] != sum[W-1]) ? (sum[W] ? ACC_MIN : ACC_MAX) : sum[W-1:0];

    assign can_step = (i_accum >= ACC_TWO) || (i_accum <= -ACC_TWO);
    assign pos      = !i_accum[W-1];
    assign flip     = P_INV_POS ? pos : !pos;

    always_comb begin
        o_accum_next   = i_accum;
        o_phase_next   = i_phase;
        o_ctl.step     = 1'b0;
        o_ctl.port_bit = !i_phase ^ flip;
        case (i_op)
            OP_REPORT: begin
                o_accum_next = sat;
            end
            OP_TICK: begin
                if (can_step) begin
                    o_ctl.step   = 1'b1;
                    o_phase_next = !i_phase;
                    o_accum_next = pos ? (i_accum - ACC_TWO) : (i_accum + ACC_TWO);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/mouse_quadrature_port_logic.sv */
// ----------------------------------------------------------------------------
// mouse_quadrature_port_logic
// Mouse motion to quadrature phase lines, with an 8-bit input port image.
// ----------------------------------------------------------------------------
// Every accepted item yields exactly one result item. Items pass through an
// input register and a result register; the state update and the result are
// computed between them, so one item is taken per clock while the result side
// is ready; the result is registered as the item leaves the input register.
// The input side keeps accepting while a result waits, until both are full.
// A report adds dx/dy to saturating ACCUM_WIDTH-bit accumulators and puts the
// primary button on port bit 3 (low while pressed). A tick steps each axis
// whose accumulator is at least 2 from zero, driving port bit 4 (X) or 5 (Y)
// and emitting the old phase level. Port bit 0 takes the clock data bit, and
// an overwrite replaces the whole port image without forwarding it.
// ----------------------------------------------------------------------------
module mouse_quadrature_port_logic #(
    parameter int unsigned ACCUM_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mqp_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mqp_pkg::t_out_item  o_out_item
);
    import mqp_pkg::*;

    // Input register
    logic      r_in_valid;
    t_in_item  r_in;

    // Block state
    logic signed [ACCUM_WIDTH-1:0] r_accum_x, n_accum_x;
    logic signed [ACCUM_WIDTH-1:0] r_accum_y, n_accum_y;
    logic                          r_phase_a, n_phase_a;
    logic                          r_phase_b, n_phase_b;
    logic [7:0]                    r_port, n_port;

    // Result register
    logic      r_out_valid;
    t_out_item r_out, n_out;

    t_axis_ctl x_ctl;
    t_axis_ctl y_ctl;
    logic      advance;

    // Move an item to the result register when that slot is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    mqp_axis #(
        .P_ACCUM_WIDTH (ACCUM_WIDTH),
        .P_INV_POS     (1'b1)
    ) u_axis_x (
        .i_op         (r_in.op),
        .i_delta      (r_in.mouse_dx),
        .i_accum      (r_accum_x),
        .i_phase      (r_phase_a),
        .o_accum_next (n_accum_x),
        .o_phase_next (n_phase_a),
        .o_ctl        (x_ctl)
    );

    // Y inverts its port bit on negative motion instead of positive
    mqp_axis #(
        .P_ACCUM_WIDTH (ACCUM_WIDTH),
        .P_INV_POS     (1'b0)
    ) u_axis_y (
        .i_op         (r_in.op),
        .i_delta      (r_in.mouse_dy),
        .i_accum      (r_accum_y),
        .i_phase      (r_phase_b),
        .o_accum_next (n_accum_y),
        .o_phase_next (n_phase_b),
        .o_ctl        (y_ctl)
    );

    // Port image update and result assembly
    always_comb begin
        n_port             = r_port;
        n_out.port_changed = 1'b0;
        unique case (r_in.op)
            OP_REPORT: begin
                n_port[BIT_BUTTON] = !r_in.buttons[0];
                n_out.port_changed = (n_port[BIT_BUTTON] != r_port[BIT_BUTTON]);
            end
            OP_TICK: begin
                if (x_ctl.step) begin
                    n_port[BIT_X] = x_ctl.port_bit;
                end
                if (y_ctl.step) begin
                    n_port[BIT_Y] = y_ctl.port_bit;
                end
                // Forward on any step, even if the image bits did not move
                n_out.port_changed = x_ctl.step || y_ctl.step;
            end
            OP_CLOCK_BIT: begin
                n_port[BIT_CLOCK]  = r_in.value[0];
                n_out.port_changed = 1'b1;
            end
            OP_OVERWRITE: begin
                n_port = r_in.value;
            end
            default: begin
            end
        endcase
        n_out.port_value    = n_port;
        n_out.phase_x_valid = x_ctl.step;
        n_out.phase_x       = x_ctl.step && r_phase_a;
        n_out.phase_y_valid = y_ctl.step;
        n_out.phase_y       = y_ctl.step && r_phase_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_accum_x   <= '0;
            r_accum_y   <= '0;
            r_phase_a   <= 1'b0;
            r_phase_b   <= 1'b0;
            r_port      <= PORT_RESET;
        end else begin
            // Capture a new item whenever the input slot is free or moving on
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            // Commit state together with the result
            if (advance) begin
                r_accum_x <= n_accum_x;
                r_accum_y <= n_accum_y;
                r_phase_a <= n_phase_a;
                r_phase_b <= n_phase_b;
                r_port    <= n_port;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_in_valid && !r_out_valid)
        else $error("pipeline not empty after reset");

    a_phase_x_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.phase_x_valid |-> !r_out.phase_x)
        else $error("X phase level without a step");

    a_phase_a_toggle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && x_ctl.step |=> r_phase_a != $past(r_phase_a))
        else $error("X phase did not toggle on a step");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_port) && $stable(r_accum_x) && $stable(r_accum_y))
        else $error("state changed without an item");
`endif

endmodule

/* verif/mouse_quadrature_port_logic_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_quadrature_port_logic_test
// Self-checking bench for the mouse quadrature port logic. A behavioral model
// of the accumulators, phase lines and port image predicts the result of
// every accepted item; results are checked in order, field by field. Runs a
// directed pass, accumulator saturation sweeps, a long output hold-off,
// random traffic with random idling on both sides, and an unbroken stream.
// ----------------------------------------------------------------------------
module mouse_quadrature_port_logic_test;
    import mqp_pkg::*;

    localparam int unsigned ACCUM_W        = 16;
    localparam longint      ACC_MAX        = (longint'(1) <<< (ACCUM_W - 1)) - 1;
    localparam longint      ACC_MIN        = -ACC_MAX - 1;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          MAX_REPORTS    = 10;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    mouse_quadrature_port_logic #(
        .ACCUM_WIDTH (ACCUM_W)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    // Model state, mirrors the block's registers
    logic signed [ACCUM_W-1:0] accum_x_model;
    logic signed [ACCUM_W-1:0] accum_y_model;
    logic                      phase_a_model;
    logic                      phase_b_model;
    logic [7:0]                port_image_model;

    t_out_item predicted_results[$];
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        idle_on        = 1'b1;
    int        hold_request   = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Port model
    // ------------------------------------------------------------------------
    function automatic logic signed [ACCUM_W-1:0] add_saturated(
        logic signed [ACCUM_W-1:0] acc, logic signed [7:0] delta);
        longint sum;
        sum = longint'(acc) + longint'(delta);
        if (sum > ACC_MAX) sum = ACC_MAX;
        if (sum < ACC_MIN) sum = ACC_MIN;
        return sum[ACCUM_W-1:0];
    endfunction

    // Advance the model by one item and return the result it must produce
    function automatic t_out_item predict_port_item(t_in_item it);
        t_out_item  r;
        logic [7:0] old_image;
        r         = '0;
        old_image = port_image_model;
        case (it.op)
            OP_REPORT: begin
                // Primary button pulls bit 3 low; forward only on a real change
                port_image_model[BIT_BUTTON] = ~it.buttons[0];
                r.port_changed = (port_image_model != old_image);
                accum_x_model  = add_saturated(accum_x_model, it.mouse_dx);
                accum_y_model  = add_saturated(accum_y_model, it.mouse_dy);
            end
            OP_TICK: begin
                if (accum_x_model >= 2 || accum_x_model <= -2) begin
                    port_image_model[BIT_X] = (accum_x_model > 0) ? phase_a_model
                                                                  : ~phase_a_model;
                    accum_x_model   = (accum_x_model > 0) ? ACCUM_W'(accum_x_model - 2)
                                                          : ACCUM_W'(accum_x_model + 2);
                    r.phase_x_valid = 1'b1;
                    r.phase_x       = phase_a_model;
                    phase_a_model   = ~phase_a_model;
                    r.port_changed  = 1'b1;
                end
                // Y direction sense is the opposite of X
                if (accum_y_model >= 2 || accum_y_model <= -2) begin
                    port_image_model[BIT_Y] = (accum_y_model > 0) ? ~phase_b_model
                                                                  : phase_b_model;
                    accum_y_model   = (accum_y_model > 0) ? ACCUM_W'(accum_y_model - 2)
                                                          : ACCUM_W'(accum_y_model + 2);
                    r.phase_y_valid = 1'b1;
                    r.phase_y       = phase_b_model;
                    phase_b_model   = ~phase_b_model;
                    r.port_changed  = 1'b1;
                end
            end
            OP_CLOCK_BIT: begin
                port_image_model[BIT_CLOCK] = it.value[0];
                r.port_changed = 1'b1;
            end
            default: begin
                // Overwrite comes from the interface chip: nothing forwarded
                port_image_model = it.value;
            end
        endcase
        r.port_value = port_image_model;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Item helpers
    // ------------------------------------------------------------------------
    function automatic t_in_item make_item(t_op op, int dx, int dy, int btn, int val);
        t_in_item it;
        it.op       = op;
        it.mouse_dx = dx[7:0];
        it.mouse_dy = dy[7:0];
        it.buttons  = btn[2:0];
        it.value    = val[7:0];
        return it;
    endfunction

    // Mostly small motion so ticks keep stepping; full-range deltas now and then
    function automatic t_in_item random_port_item();
        t_in_item it;
        int       pick;
        it   = t_in_item'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            it.op = OP_REPORT;
            if ($urandom_range(0, 3) != 0) begin
                it.mouse_dx = 8'($urandom_range(0, 12) - 6);
                it.mouse_dy = 8'($urandom_range(0, 12) - 6);
            end
        end else if (pick < 75) begin
            it.op = OP_TICK;
        end else if (pick < 90) begin
            it.op = OP_CLOCK_BIT;
        end else begin
            it.op = OP_OVERWRITE;
        end
        return it;
    endfunction

    // Offer one item, hold it until accepted, then record its prediction.
    // Valid stays high after acceptance; it drops only ahead of an idle gap.
    task automatic send_port_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        predicted_results.push_back(predict_port_item(it));
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus a long hold-off on request
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end else if (stall_left == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("mismatch %s: expected %0h, got %0h", name, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (predicted_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected result item %h", o_out_item);
                end
            end else begin
                want = predicted_results.pop_front();
                check_field("port_value",    want.port_value,    o_out_item.port_value);
                check_field("port_changed",  8'(want.port_changed),
                            8'(o_out_item.port_changed));
                check_field("phase_x_valid", 8'(want.phase_x_valid),
                            8'(o_out_item.phase_x_valid));
                check_field("phase_x",       8'(want.phase_x),
                            8'(o_out_item.phase_x));
                check_field("phase_y_valid", 8'(want.phase_y_valid),
                            8'(o_out_item.phase_y_valid));
                check_field("phase_y",       8'(want.phase_y),
                            8'(o_out_item.phase_y));
            end
        end
    end

    // Watchdog: end the run when neither side moves an item for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding",
                         predicted_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        // Idle tick straight out of reset
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        // Button released while bit 3 is already high: no forward
        send_port_item(make_item(OP_REPORT, 1, -1, 0, 0));
        // One count per axis is below the step threshold
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        // Press the button and bring the axes to exactly +2 and -2
        send_port_item(make_item(OP_REPORT, 1, -1, 1, 8'hff));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        // Extreme deltas, button released with the other mask bits set, then pressed
        send_port_item(make_item(OP_REPORT, 127, -128, 6, 0));
        send_port_item(make_item(OP_REPORT, -128, 127, 7, 0));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        // Step from -2 on X and +2 on Y
        send_port_item(make_item(OP_REPORT, -1, 3, 0, 0));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        // X alone steps, then Y alone in the negative direction
        send_port_item(make_item(OP_REPORT, 5, 0, 1, 8'h55));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_port_item(make_item(OP_REPORT, 0, -4, 0, 0));
        send_port_item(make_item(OP_TICK, 7, 7, 7, 8'hff));
        // Clock data bit: only bit 0 of value counts
        send_port_item(make_item(OP_CLOCK_BIT, -1, -1, 7, 8'h01));
        send_port_item(make_item(OP_CLOCK_BIT, 0, 0, 0, 8'hfe));
        send_port_item(make_item(OP_CLOCK_BIT, 0, 0, 0, 8'hff));
        send_port_item(make_item(OP_CLOCK_BIT, 0, 0, 0, 8'h00));
        // Overwrites, with a step and a button press on top of them
        send_port_item(make_item(OP_OVERWRITE, 127, 127, 1, 8'h00));
        send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
        send_port_item(make_item(OP_OVERWRITE, -128, -128, 6, 8'hff));
        send_port_item(make_item(OP_REPORT, 0, 0, 1, 0));
        send_port_item(make_item(OP_OVERWRITE, 0, 0, 0, 8'ha5));
    endtask

    // Repeat one motion report, with a tick now and then to step off the rail
    task automatic drive_motion(int count, int dx, int dy);
        for (int n = 0; n < count; n++) begin
            send_port_item(make_item(OP_REPORT, dx, dy, $urandom_range(0, 7),
                                     $urandom_range(0, 255)));
            if (n % 32 == 31) begin
                send_port_item(make_item(OP_TICK, 0, 0, 0, 0));
            end
        end
    endtask

    // Drive each axis into one rail, then across into the opposite rail
    task automatic test_saturation();
        drive_motion(260, 127, -128);
        drive_motion(520, -128, 127);
    endtask

    // Hold the result side off while items keep coming, so the block fills
    task automatic test_back_pressure();
        idle_on      = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (30) send_port_item(random_port_item());
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic(int count);
        repeat (count) send_port_item(random_port_item());
    endtask

    // Back-to-back items with both sides always ready
    task automatic test_steady_stream(int count);
        idle_on = 1'b0;
        repeat (count) send_port_item(random_port_item());
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        accum_x_model    = '0;
        accum_y_model    = '0;
        phase_a_model    = 1'b0;
        phase_b_model    = 1'b0;
        port_image_model = PORT_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_saturation();
        test_back_pressure();
        test_random_traffic(350);
        test_steady_stream(120);

        // Drop valid, drain outstanding results, then allow for stray ones
        i_in_valid <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatch_count == 0 && predicted_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* files.f */
hdl/mqp_pkg.sv
hdl/mqp_axis.sv
hdl/mouse_quadrature_port_logic.sv
verif/mouse_quadrature_port_logic_test.sv
